### hw/rtl/rfcp_pkg.sv
package rfcp_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] PRESS_TICKS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] RELEASE_GAP_RST = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_TICKS = 1'b0,
        CFG_RELEASE_GAP = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] press_ticks;
        logic [CFG_W-1:0] release_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              code_valid;
        logic [CODE_W-1:0] code_value;
    } poll_t;

    typedef struct packed {
        logic              click_event;
        logic              long_start_event;
        logic              long_during_event;
        logic              long_stop_event;
        logic [CODE_W-1:0] event_code;
        logic              long_pressed;
        logic [TIME_W-1:0] pressed_ms;
    } result_t;

endpackage

### hw/rtl/rfcp_core.sv
module rfcp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  rfcp_pkg::poll_t  poll,
    input  rfcp_pkg::cfg_t   cfg,
    output rfcp_pkg::result_t res
);
    import rfcp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] start_time_reg, start_time_next;
    logic [TIME_W-1:0] stop_time_reg, stop_time_next;
    logic [TIME_W-1:0] last_code_time_reg, last_code_time_next;
    logic [CODE_W-1:0] last_code_reg, last_code_next;
    logic              long_flag_reg, long_flag_next;

    logic              active;
    logic              silent;
    logic              long_due;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] held;

    // gap uses the stored code time; silent is only meaningful without a code
    assign active   = poll.code_valid;
    assign gap      = poll.now_ms - last_code_time_reg;
    assign held     = poll.now_ms - start_time_reg;
    assign silent   = !active && (gap > {{(TIME_W-CFG_W){1'b0}}, cfg.release_gap_ms});
    assign long_due = active && (held > {{(TIME_W-CFG_W){1'b0}}, cfg.press_ticks});

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (active) phase_next = PH_PRESSED;
            end
            PH_PRESSED: begin
                if (silent)        phase_next = PH_RELEASED;
                else if (long_due) phase_next = PH_LONG;
            end
            PH_RELEASED: phase_next = PH_IDLE;
            PH_LONG: begin
                if (silent) phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // datapath updates and events
    always_comb begin
        start_time_next     = start_time_reg;
        stop_time_next      = stop_time_reg;
        long_flag_next      = long_flag_reg;
        last_code_next      = active ? poll.code_value : last_code_reg;
        last_code_time_next = active ? poll.now_ms : last_code_time_reg;
        res.click_event       = 1'b0;
        res.long_start_event  = 1'b0;
        res.long_during_event = 1'b0;
        res.long_stop_event   = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (active) start_time_next = poll.now_ms;
            end
            PH_PRESSED: begin
                if (silent) begin
                    stop_time_next = poll.now_ms;
                end else if (long_due) begin
                    stop_time_next        = poll.now_ms;
                    long_flag_next        = 1'b1;
                    res.long_start_event  = 1'b1;
                    res.long_during_event = 1'b1;
                end
            end
            PH_RELEASED: res.click_event = 1'b1;
            PH_LONG: begin
                if (silent) begin
                    stop_time_next      = poll.now_ms;
                    long_flag_next      = 1'b0;
                    res.long_stop_event = 1'b1;
                end else begin
                    long_flag_next        = 1'b1;
                    res.long_during_event = 1'b1;
                end
            end
            default: ;
        endcase
        res.event_code   = last_code_next;
        res.long_pressed = long_flag_next;
        res.pressed_ms   = stop_time_next - start_time_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            start_time_reg     <= '0;
            stop_time_reg      <= '0;
            last_code_time_reg <= '0;
            last_code_reg      <= '0;
            long_flag_reg      <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            start_time_reg     <= start_time_next;
            stop_time_reg      <= stop_time_next;
            last_code_time_reg <= last_code_time_next;
            last_code_reg      <= last_code_next;
            long_flag_reg      <= long_flag_next;
        end
    end

    a_flag_tracks_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        long_flag_reg == (phase_reg == PH_LONG))
        else $error("long flag out of step with phase");

    a_events_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> $onehot0({res.click_event, res.long_during_event, res.long_stop_event}))
        else $error("conflicting events in one poll");

    a_click_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_RELEASED) |=> phase_reg == PH_IDLE)
        else $error("click poll did not return to idle");

    a_start_enters_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.long_start_event) |=> phase_reg == PH_LONG)
        else $error("long start without long phase");

endmodule

### hw/rtl/rf_code_press_classifier_unit.sv
// Remote-code press classifier. Each input transfer is one poll: the current
// millisecond time and an optional received code. Every poll yields exactly
// one result transfer carrying click / long-start / during-long / long-stop
// events, the code for this poll (or the last code seen, 0 before any),
// the long-press flag and stop minus start time. Throughput is one poll per
// clock while the result channel is not stalled. The poll lands in the
// input register at its transfer edge, and the classifier step then writes
// the result register, which drives result valid. The press state advances
// as each poll leaves the input register, so results stay in order under
// any stall pattern. press_ticks (index 0, reset 1000) and release_gap_ms
// (index 1, reset 200) are written via cfg_wr_en; the user must write them
// only while the block is idle; the block does not enforce this. All time
// differences wrap modulo 2^32.
module rf_code_press_classifier_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write port
    input  logic                          cfg_wr_en,
    input  logic [rfcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfcp_pkg::CFG_W-1:0]    cfg_wdata,
    // poll channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rfcp_pkg::TIME_W-1:0]   s_now_ms,
    input  logic                          s_code_valid,
    input  logic [rfcp_pkg::CODE_W-1:0]   s_code_value,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_click_event,
    output logic                          m_long_start_event,
    output logic                          m_long_during_event,
    output logic                          m_long_stop_event,
    output logic [rfcp_pkg::CODE_W-1:0]   m_event_code,
    output logic                          m_long_pressed,
    output logic [rfcp_pkg::TIME_W-1:0]   m_pressed_ms
);
    import rfcp_pkg::*;

    cfg_t    cfg_reg;
    poll_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t res;
    logic    advance;   // result register can take a new value
    logic    step;      // input register moves into the classifier

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_ticks    <= PRESS_TICKS_RST;
            cfg_reg.release_gap_ms <= RELEASE_GAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRESS_TICKS: cfg_reg.press_ticks    <= cfg_wdata;
                CFG_RELEASE_GAP: cfg_reg.release_gap_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.now_ms     <= s_now_ms;
            in_reg.code_valid <= s_code_valid;
            in_reg.code_value <= s_code_value;
        end
    end

    rfcp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .poll    (in_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) out_reg <= res;
    end

    assign m_valid             = out_valid_reg;
    assign m_click_event       = out_reg.click_event;
    assign m_long_start_event  = out_reg.long_start_event;
    assign m_long_during_event = out_reg.long_during_event;
    assign m_long_stop_event   = out_reg.long_stop_event;
    assign m_event_code        = out_reg.event_code;
    assign m_long_pressed      = out_reg.long_pressed;
    assign m_pressed_ms        = out_reg.pressed_ms;

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");

    a_result_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("classified poll lost");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(out_reg))
        else $error("stalled result changed");

endmodule
